/* rtl/assert_macros.svh */
// Assertion macros shared by the ordered list engine RTL.
// Needs a signal named clock and a signal named reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define OLE_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication.
`define OLE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ole_pkg.sv */
// Package for the ordered list engine: field widths, operation and status codes,
// cell command struct and controller states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ole_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int FUNC_W           = 3;
   localparam int INDEX_W          = 7;
   localparam int VALUE_W          = 32;
   localparam int STATUS_W         = 2;
   localparam int COUNT_W          = 7;
   localparam int GROUP_SIZE       = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT      = 3'd0,
      FUNC_DELETE      = 3'd1,
      FUNC_SEARCH      = 3'd2,
      FUNC_APPEND      = 3'd3,
      FUNC_REMOVE_LAST = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_SEARCH
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GROUP,
      ST_FOUND,
      ST_DELIVER
   } state_type;

endpackage

`default_nettype wire

/* rtl/ole_req_if.sv */
// Request channel of the ordered list engine: valid/ready plus operation fields.
// Depends on ole_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ole_req_if;
   logic                              valid;
   logic                              ready;
   logic [ole_pkg::FUNC_W-1:0]        func;
   logic [ole_pkg::INDEX_W-1:0]       index;
   logic signed [ole_pkg::VALUE_W-1:0] value;

   modport source (output valid, output func, output index, output value, input ready);
   modport sink   (input valid, input func, input index, input value, output ready);
endinterface

`default_nettype wire

/* rtl/ole_rsp_if.sv */
// Response channel of the ordered list engine: valid/ready plus result fields.
// Depends on ole_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ole_rsp_if;
   logic                         valid;
   logic                         ready;
   ole_pkg::status_type          status;
   logic                         found;
   logic [ole_pkg::COUNT_W-1:0]  count;

   modport source (output valid, output status, output found, output count, input ready);
   modport sink   (input valid, input status, input found, input count, output ready);
endinterface

`default_nettype wire

/* rtl/ole_cell.sv */
// One list cell: holds a single entry, shifts with its neighbors on insert/delete
// and flags a match on search. Depends on ole_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ole_cell #(
   parameter int CELL_POS = 0,
   parameter int IDX_W    = 6,
   parameter int CNT_W    = 7
) (
   input  wire                                  clock,
   input  wire ole_pkg::cell_cmd_type           cmd,
   input  wire [IDX_W-1:0]                      cmd_pos,
   input  wire [CNT_W-1:0]                      count,
   input  wire signed [ole_pkg::VALUE_W-1:0]    left_data,
   input  wire signed [ole_pkg::VALUE_W-1:0]    right_data,
   output logic signed [ole_pkg::VALUE_W-1:0]   data,
   output logic                                 hit
);

   localparam logic [IDX_W-1:0] MY_POS = IDX_W'(CELL_POS);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_POS);

   logic signed [ole_pkg::VALUE_W-1:0] data_ff, data_in;
   logic                               hit_ff, hit_in;

   always_comb begin
      data_in = data_ff;
      hit_in  = hit_ff;
      case (cmd.op)
         ole_pkg::CELL_INSERT: begin
            hit_in = 1'b0;
            if (MY_POS > cmd_pos) begin
               data_in = left_data;
            end else if (MY_POS == cmd_pos) begin
               data_in = cmd.value;
            end
         end
         ole_pkg::CELL_DELETE: begin
            hit_in = 1'b0;
            if (MY_POS >= cmd_pos) begin
               data_in = right_data;
            end
         end
         ole_pkg::CELL_SEARCH: begin
            // only occupied positions may report a match
            hit_in = (MY_CNT < count) && (data_ff == cmd.value);
         end
         default: begin
            // hold keeps the last match so the reduction tree sees a stable vector
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule

`default_nettype wire

/* rtl/ole_hit_reduce.sv */
// Registered two-level OR tree over the per-cell match flags.
// Depends on ole_pkg for the group size.
`timescale 1ns / 1ps
`default_nettype none

module ole_hit_reduce #(
   parameter int CAPACITY = ole_pkg::CAPACITY_DEFAULT
) (
   input  wire                  clock,
   input  wire [CAPACITY-1:0]   hits,
   output logic                 found
);

   localparam int GS     = ole_pkg::GROUP_SIZE;
   localparam int GROUPS = (CAPACITY + GS - 1) / GS;

   logic [GROUPS-1:0] group_ff, group_in;
   logic              found_ff;

   for (genvar g = 0; g < GROUPS; g++) begin : g_group
      localparam int LO = g * GS;
      localparam int HI = ((LO + GS) < CAPACITY) ? (LO + GS - 1) : (CAPACITY - 1);
      assign group_in[g] = |hits[HI:LO];
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      found_ff <= |group_ff;
   end

   assign found = found_ff;

endmodule

`default_nettype wire

/* rtl/ordered_list_engine.sv */
// Top level of the ordered list engine: request decode, cell row, match tree,
// result register. Depends on ole_pkg, ole_req_if, ole_rsp_if, ole_cell, ole_hit_reduce.
//
//   channel   dir  fields                         handshake
//   req_chan  in   func[2:0] index[6:0] value[31:0] valid/ready
//   rsp_chan  out  status[1:0] found count[6:0]   valid/ready
//
// Each transaction updates the cell row, runs the group and final levels of the
// registered match tree, then loads the result register.
// A new request is taken once the previous result is in the result register, so the
// result can wait for rsp_chan.ready while the next request is already in work.
// Synchronous reset empties the list; entries themselves are not cleared.
// A stalled result holds the controller in its delivery state until taken.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ordered_list_engine #(
   parameter int CAPACITY = ole_pkg::CAPACITY_DEFAULT
) (
   input wire        clock,
   input wire        reset,
   ole_req_if.sink   req_chan,
   ole_rsp_if.source rsp_chan
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (ole_pkg::INDEX_W > CNT_W) ? ole_pkg::INDEX_W : CNT_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   ole_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]           count_ff, count_in;
   ole_pkg::status_type        pend_status_ff, pend_status_in;
   logic [ole_pkg::COUNT_W-1:0] pend_count_ff, pend_count_in;
   logic                       pend_search_ff, pend_search_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   ole_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [ole_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                  req_accept;
   logic [CMP_W-1:0]      cnt_ext, idx_ext;
   logic [CNT_W-1:0]      last_pos;
   logic                  list_full, list_empty;
   ole_pkg::status_type   dec_status;
   ole_pkg::cell_op_type  dec_op;
   logic [IDX_W-1:0]      dec_pos;
   logic [CNT_W-1:0]      dec_count;
   ole_pkg::cell_cmd_type cell_cmd;
   logic                  load_rsp;
   logic                  tree_found;

   logic signed [ole_pkg::VALUE_W-1:0] entry_q [CAPACITY];
   logic [CAPACITY-1:0]                hit_vec;

   assign req_chan.ready = (state_ff == ole_pkg::ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign cnt_ext    = CMP_W'(count_ff);
   assign idx_ext    = CMP_W'(req_chan.index);
   assign last_pos   = count_ff - CNT_W'(1);
   assign list_full  = (count_ff == FULL_CNT);
   assign list_empty = (count_ff == '0);

   // request decode
   always_comb begin
      dec_status = ole_pkg::STATUS_OK;
      dec_op     = ole_pkg::CELL_HOLD;
      dec_pos    = idx_ext[IDX_W-1:0];
      dec_count  = count_ff;
      case (ole_pkg::func_type'(req_chan.func))
         ole_pkg::FUNC_INSERT: begin
            if (idx_ext > cnt_ext) begin
               dec_status = ole_pkg::STATUS_BAD_INDEX;
            end else if (list_full) begin
               dec_status = ole_pkg::STATUS_FULL;
            end else begin
               dec_op    = ole_pkg::CELL_INSERT;
               dec_count = count_ff + CNT_W'(1);
            end
         end
         ole_pkg::FUNC_APPEND: begin
            dec_pos = cnt_ext[IDX_W-1:0];
            if (list_full) begin
               dec_status = ole_pkg::STATUS_FULL;
            end else begin
               dec_op    = ole_pkg::CELL_INSERT;
               dec_count = count_ff + CNT_W'(1);
            end
         end
         ole_pkg::FUNC_DELETE: begin
            if (list_empty) begin
               dec_status = ole_pkg::STATUS_EMPTY;
            end else if (idx_ext >= cnt_ext) begin
               dec_status = ole_pkg::STATUS_BAD_INDEX;
            end else begin
               dec_op    = ole_pkg::CELL_DELETE;
               dec_count = last_pos;
            end
         end
         ole_pkg::FUNC_REMOVE_LAST: begin
            dec_pos = last_pos[IDX_W-1:0];
            if (list_empty) begin
               dec_status = ole_pkg::STATUS_EMPTY;
            end else begin
               dec_op    = ole_pkg::CELL_DELETE;
               dec_count = last_pos;
            end
         end
         ole_pkg::FUNC_SEARCH: begin
            dec_op = ole_pkg::CELL_SEARCH;
         end
         default: begin
            dec_status = ole_pkg::STATUS_BAD_INDEX;
         end
      endcase
   end

   assign cell_cmd.op    = req_accept ? dec_op : ole_pkg::CELL_HOLD;
   assign cell_cmd.value = req_chan.value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [ole_pkg::VALUE_W-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_left
         assign left_d = entry_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_right
         assign right_d = entry_q[i+1];
      end
      ole_cell #(
         .CELL_POS (i),
         .IDX_W    (IDX_W),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .cmd_pos    (dec_pos),
         .count      (count_ff),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (entry_q[i]),
         .hit        (hit_vec[i])
      );
   end

   ole_hit_reduce #(
      .CAPACITY (CAPACITY)
   ) u_reduce (
      .clock (clock),
      .hits  (hit_vec),
      .found (tree_found)
   );

   // controller: next state, pending result, result register
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      pend_status_in = pend_status_ff;
      pend_count_in  = pend_count_ff;
      pend_search_in = pend_search_ff;
      load_rsp       = 1'b0;
      case (state_ff)
         ole_pkg::ST_IDLE: begin
            if (req_accept) begin
               count_in       = dec_count;
               pend_status_in = dec_status;
               pend_count_in  = ole_pkg::COUNT_W'(dec_count);
               pend_search_in = (dec_op == ole_pkg::CELL_SEARCH);
               state_in       = ole_pkg::ST_GROUP;
            end
         end
         ole_pkg::ST_GROUP: begin
            state_in = ole_pkg::ST_FOUND;
         end
         ole_pkg::ST_FOUND: begin
            state_in = ole_pkg::ST_DELIVER;
         end
         ole_pkg::ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = ole_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ole_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_found_in  = pend_search_ff && tree_found;
         rsp_count_in  = pend_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ole_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_count_ff  <= pend_count_in;
      pend_search_ff <= pend_search_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.found  = rsp_found_ff;
   assign rsp_chan.count  = rsp_count_ff;

   `OLE_ASSERT(a_count_bound, count_ff <= FULL_CNT, "entry count above capacity")
   `OLE_ASSERT_IMPL(a_count_still, !$past(req_accept), $stable(count_ff), "count moved without request")
   `OLE_ASSERT(a_count_step, (count_ff == $past(count_ff)) || (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))) || (count_ff == CNT_W'($past(count_ff) - CNT_W'(1))), "count moved by more than one")
   `OLE_ASSERT_NEXT(a_one_in_flight, req_accept, !req_chan.ready, "request taken while busy")

endmodule

`default_nettype wire
